@@ rtl/core/apq_pkg.sv @@
`default_nettype none

package apq_pkg;

  localparam int PRICE_W = 16;
  localparam int COUNT_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 8'd3;

  // operation carried in the kind field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SERVE  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_SEL,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

  // request to the shared compare / increment unit
  typedef struct packed {
    logic [PRICE_W-1:0] a;
    logic [PRICE_W-1:0] b;
    logic [COUNT_W-1:0] cnt;
  } cmp_req_t;

  typedef struct packed {
    logic               ge;
    logic [COUNT_W-1:0] cnt_inc;
  } cmp_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/apq_cmp_unit.sv @@
`default_nettype none

module apq_cmp_unit (
  input  wire apq_pkg::cmp_req_t req,
  output apq_pkg::cmp_rsp_t      rsp
);

  always_comb begin
    rsp.ge      = (req.a >= req.b);
    // pass-over count saturates
    rsp.cnt_inc = (req.cnt == apq_pkg::COUNT_MAX) ? req.cnt
                                                  : req.cnt + apq_pkg::COUNT_W'(1);
  end

endmodule

`default_nettype wire

@@ rtl/core/aging_priority_queue.sv @@
`default_nettype none

// Sorted queue of up to DEPTH entries (price, pass-over count) with aging.
// Input channel (in_valid / in_stall): kind 0 inserts price, kind 1 serves.
// Output channel (out_valid / out_stall): one result beat per input beat,
// status plus the served entry's price and count (zero unless served).
// cfg_write / cfg_data load the aging threshold; write only while idle.
// One item is worked at a time; in_stall is high from accept until the
// result is handed to the output register. The entry memory has one read
// and one write port and is walked one entry per cycle:
//   insert:            one pass that places the price and shifts the rest up
//   serve:             a select scan, then a close-up pass
//   full or empty:     no walk; the status goes straight to the result
// The output register holds a result while out_stall is high; the next item
// may be accepted meanwhile, and its result waits until the register frees.
// Synchronous reset empties the queue, drops any pending result and sets
// the threshold to 3. Entry contents are not cleared; the fill count
// guards every read.
module aging_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [15:0] price,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [15:0]      served_price,
  output logic [7:0]       served_passed_over,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW = $clog2(DEPTH + 1);

  apq_pkg::state_t state, state_next;

  apq_pkg::entry_t mem [DEPTH];
  apq_pkg::entry_t rd_data;
  apq_pkg::entry_t wr_data;
  apq_pkg::entry_t carry;
  apq_pkg::entry_t sel_ent;

  logic [IW-1:0] idx;
  logic [IW-1:0] pk;
  logic [IW-1:0] fill;
  logic [IW-1:0] last;
  logic          pv;
  logic          step;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [15:0] op_price;
  logic        placed;
  logic        gfound;
  logic        gdone;
  logic [7:0]  gcnt;
  logic [AW-1:0] sel;
  logic [AW-1:0] sel_now;
  logic        take;
  logic        ins_hit;
  logic        ins_end;
  logic        sel_end;
  logic        shift_end;
  logic        out_load;
  logic [7:0]  thresh;

  apq_pkg::status_t res_status;
  logic [15:0]      res_price;
  logic [7:0]       res_cnt;

  apq_pkg::cmp_req_t cmp_req;
  apq_pkg::cmp_rsp_t cmp_rsp;

  apq_cmp_unit u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  assign in_stall = (state != apq_pkg::S_IDLE);
  assign last     = fill - IW'(1);
  assign out_load = (state == apq_pkg::S_DONE) && (!out_valid || !out_stall);

  // datapath control
  always_comb begin
    cmp_req   = '0;
    step      = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = pk[AW-1:0];
    wr_data   = rd_data;
    ins_hit   = 1'b0;
    ins_end   = 1'b0;
    sel_end   = 1'b0;
    shift_end = 1'b0;
    take      = 1'b0;
    sel_now   = sel;
    unique case (state)
      apq_pkg::S_INS: begin
        cmp_req.a   = rd_data.price;
        cmp_req.b   = op_price;
        cmp_req.cnt = rd_data.cnt;
        step        = (idx <= fill);
        rd_en       = (idx < fill);
        ins_end     = pv && (pk == fill);
        ins_hit     = !placed && (ins_end || cmp_rsp.ge);
        wr_en       = pv;
        if (placed) begin
          wr_data = carry;
        end else if (ins_hit) begin
          wr_data.price = op_price;
          wr_data.cnt   = '0;
        end else begin
          wr_data.price = rd_data.price;
          wr_data.cnt   = cmp_rsp.cnt_inc;
        end
      end
      apq_pkg::S_SEL: begin
        cmp_req.a   = {8'd0, rd_data.cnt};
        cmp_req.b   = {8'd0, (gfound ? gcnt : thresh)};
        cmp_req.cnt = rd_data.cnt;
        step        = (idx < fill);
        rd_en       = step;
        // the last entry only wins when no aged entry was found
        take        = pv && !gdone && ((pk != last) ? cmp_rsp.ge : !gfound);
        sel_now     = take ? pk[AW-1:0] : sel;
        sel_end     = pv && (pk == last);
      end
      apq_pkg::S_SHIFT: begin
        step      = (idx < fill);
        rd_en     = step;
        wr_en     = pv;
        wr_addr   = AW'(pk - IW'(1));
        wr_data   = rd_data;
        shift_end = !step && !pv;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      apq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (kind == apq_pkg::OP_INSERT) begin
            state_next = (fill == IW'(DEPTH)) ? apq_pkg::S_DONE : apq_pkg::S_INS;
          end else begin
            state_next = (fill == '0) ? apq_pkg::S_DONE : apq_pkg::S_SEL;
          end
        end
      end
      apq_pkg::S_INS: begin
        if (ins_end) state_next = apq_pkg::S_DONE;
      end
      apq_pkg::S_SEL: begin
        if (sel_end) state_next = apq_pkg::S_SHIFT;
      end
      apq_pkg::S_SHIFT: begin
        if (shift_end) state_next = apq_pkg::S_DONE;
      end
      apq_pkg::S_DONE: begin
        if (out_load) state_next = apq_pkg::S_IDLE;
      end
      default: state_next = apq_pkg::S_IDLE;
    endcase
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[idx[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= apq_pkg::S_IDLE;
      fill      <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
      thresh    <= apq_pkg::THRESH_RESET;
    end else begin
      state <= state_next;
      pv    <= step;
      if (cfg_write) thresh <= cfg_data;
      if (ins_end) fill <= fill + IW'(1);
      if (state == apq_pkg::S_SHIFT && shift_end) fill <= fill - IW'(1);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    pk <= idx;
    if (step) idx <= idx + IW'(1);
    unique case (state)
      apq_pkg::S_IDLE: begin
        idx      <= '0;
        op_price <= price;
        placed   <= 1'b0;
        gfound   <= 1'b0;
        gdone    <= 1'b0;
        sel      <= '0;
        res_price <= '0;
        res_cnt   <= '0;
        if (kind == apq_pkg::OP_INSERT) begin
          res_status <= (fill == IW'(DEPTH)) ? apq_pkg::ST_FULL : apq_pkg::ST_INSERTED;
        end else begin
          res_status <= (fill == '0) ? apq_pkg::ST_EMPTY : apq_pkg::ST_SERVED;
        end
      end
      apq_pkg::S_INS: begin
        if (pv) begin
          if (placed || ins_hit) carry <= rd_data;
          if (ins_hit) placed <= 1'b1;
        end
      end
      apq_pkg::S_SEL: begin
        if (take) begin
          sel     <= pk[AW-1:0];
          sel_ent <= rd_data;
          if (!gfound) begin
            gfound <= 1'b1;
            gcnt   <= rd_data.cnt;
          end else begin
            gdone <= 1'b1;
          end
        end
        if (sel_end) idx <= IW'(sel_now) + IW'(1);
      end
      apq_pkg::S_SHIFT: begin
        if (shift_end) begin
          res_price <= sel_ent.price;
          res_cnt   <= sel_ent.cnt;
        end
      end
      apq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status             <= res_status;
      served_price       <= res_price;
      served_passed_over <= res_cnt;
    end
  end

endmodule

`default_nettype wire

@@ test/tb_aging_priority_queue.sv @@
`default_nettype none

module tb_aging_priority_queue;

  localparam int BOOK_DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    apq_pkg::status_t            st;
    logic [apq_pkg::PRICE_W-1:0] price;
    logic [apq_pkg::COUNT_W-1:0] cnt;
  } outcome_t;

  // one row of the directed table; reps beats with price stepping by step
  typedef struct packed {
    logic                        kind;
    logic [apq_pkg::PRICE_W-1:0] price;
    logic [4:0]                  reps;
    logic [apq_pkg::PRICE_W-1:0] step;
    logic                        typed;
    apq_pkg::status_t            st;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [15:0] price;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [15:0] served_price;
  logic [7:0]  served_passed_over;
  logic        cfg_write;
  logic [7:0]  cfg_data;

  // predictor copy of the price book
  logic [apq_pkg::PRICE_W-1:0] book_price [BOOK_DEPTH];
  logic [apq_pkg::COUNT_W-1:0] book_count [BOOK_DEPTH];
  int                          book_fill;
  logic [apq_pkg::COUNT_W-1:0] aging_thr;

  outcome_t pending_outcomes [$];
  dir_row_t dir_rows [$];
  outcome_t want;
  int       mismatches = 0;
  int       results_seen = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  bit       held_long = 0;

  aging_priority_queue #(.DEPTH(BOOK_DEPTH)) i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .kind               (kind),
    .price              (price),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .served_price       (served_price),
    .served_passed_over (served_passed_over),
    .cfg_write          (cfg_write),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic outcome_t apply_to_book(input logic k,
                                             input logic [apq_pkg::PRICE_W-1:0] p);
    outcome_t res;
    int pos;
    int last;
    int g;
    int s;
    bit found;
    res.st = apq_pkg::ST_INSERTED;
    res.price = '0;
    res.cnt = '0;
    if (k == apq_pkg::OP_INSERT) begin
      if (book_fill >= BOOK_DEPTH) begin
        res.st = apq_pkg::ST_FULL;
        return res;
      end
      pos = book_fill;
      found = 0;
      for (int i = 0; i < book_fill; i++) begin
        if (!found && book_price[i] >= p) begin
          pos = i;
          found = 1;
        end
      end
      // everything cheaper was passed over once more
      for (int i = 0; i < pos; i++)
        if (book_count[i] < apq_pkg::COUNT_MAX) book_count[i] = book_count[i] + 1'b1;
      for (int i = book_fill; i > pos; i--) begin
        book_price[i] = book_price[i-1];
        book_count[i] = book_count[i-1];
      end
      book_price[pos] = p;
      book_count[pos] = '0;
      book_fill++;
      return res;
    end
    if (book_fill == 0) begin
      res.st = apq_pkg::ST_EMPTY;
      return res;
    end
    last = book_fill - 1;
    g = last;
    for (int i = 0; i < last; i++)
      if (g == last && book_count[i] >= aging_thr) g = i;
    s = g;
    if (g != last) begin
      found = 0;
      for (int i = g + 1; i < last; i++) begin
        if (!found && book_count[i] >= book_count[g]) begin
          s = i;
          found = 1;
        end
      end
    end
    res.st = apq_pkg::ST_SERVED;
    res.price = book_price[s];
    res.cnt = book_count[s];
    for (int i = s; i + 1 < book_fill; i++) begin
      book_price[i] = book_price[i+1];
      book_count[i] = book_count[i+1];
    end
    book_fill--;
    return res;
  endfunction

  // mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic [apq_pkg::PRICE_W-1:0] pick_price();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_item(input logic k, input logic [apq_pkg::PRICE_W-1:0] p,
                           input logic typed, input apq_pkg::status_t st);
    int gap;
    outcome_t pred;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      price = 16'($urandom);
    end
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    price = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_to_book(k, p);
    if (typed) begin
      pred.st = st;
      pred.price = '0;
      pred.cnt = '0;
    end
    pending_outcomes.push_back(pred);
  endtask

  task automatic add_row(input logic k, input logic [apq_pkg::PRICE_W-1:0] p, input int reps,
                         input logic [apq_pkg::PRICE_W-1:0] step, input logic typed,
                         input apq_pkg::status_t st);
    dir_row_t row;
    row.kind = k;
    row.price = p;
    row.reps = 5'(reps);
    row.step = step;
    row.typed = typed;
    row.st = st;
    dir_rows.push_back(row);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [7:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
    aging_thr = v;
  endtask

  task automatic run_random(input int n);
    int mode;
    int r;
    logic k;
    mode = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mode)
        0: k = (r < 75) ? apq_pkg::OP_INSERT : apq_pkg::OP_SERVE;
        1: k = (r < 25) ? apq_pkg::OP_INSERT : apq_pkg::OP_SERVE;
        default: k = (r < 50) ? apq_pkg::OP_INSERT : apq_pkg::OP_SERVE;
      endcase
      send_item(k, pick_price(), 1'b0, apq_pkg::ST_INSERTED);
    end
  endtask

  // keep a zero-price entry at the head long enough to pin its count at the top
  task automatic run_saturation();
    while (book_fill > 0) send_item(apq_pkg::OP_SERVE, pick_price(), 1'b0, apq_pkg::ST_INSERTED);
    send_item(apq_pkg::OP_INSERT, 16'h0000, 1'b0, apq_pkg::ST_INSERTED);
    for (int i = 0; i < 130; i++) begin
      send_item(apq_pkg::OP_INSERT, 16'($urandom_range(1, 65535)), 1'b0, apq_pkg::ST_INSERTED);
      send_item(apq_pkg::OP_INSERT, 16'($urandom_range(1, 65535)), 1'b0, apq_pkg::ST_INSERTED);
      send_item(apq_pkg::OP_SERVE, pick_price(), 1'b0, apq_pkg::ST_INSERTED);
      send_item(apq_pkg::OP_SERVE, pick_price(), 1'b0, apq_pkg::ST_INSERTED);
    end
  endtask

  initial begin
    logic [apq_pkg::PRICE_W-1:0] p;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = apq_pkg::OP_INSERT;
    price = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    book_fill = 0;
    aging_thr = apq_pkg::THRESH_RESET;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      book_price[i] = '0;
      book_count[i] = '0;
    end

    add_row(apq_pkg::OP_SERVE,  16'h0000, 1,  16'h0000, 1'b1, apq_pkg::ST_EMPTY);
    add_row(apq_pkg::OP_INSERT, 16'hFFFF, 1,  16'h0000, 1'b1, apq_pkg::ST_INSERTED);
    add_row(apq_pkg::OP_INSERT, 16'h0000, 1,  16'h0000, 1'b1, apq_pkg::ST_INSERTED);
    // tie goes in front
    add_row(apq_pkg::OP_INSERT, 16'h0000, 1,  16'h0000, 1'b1, apq_pkg::ST_INSERTED);
    add_row(apq_pkg::OP_INSERT, 16'h8000, 1,  16'h0000, 1'b1, apq_pkg::ST_INSERTED);
    add_row(apq_pkg::OP_SERVE,  16'hFFFF, 4,  16'h0000, 1'b0, apq_pkg::ST_SERVED);
    add_row(apq_pkg::OP_SERVE,  16'h5A5A, 1,  16'h0000, 1'b1, apq_pkg::ST_EMPTY);
    add_row(apq_pkg::OP_INSERT, 16'h0100, 16, 16'h1111, 1'b1, apq_pkg::ST_INSERTED);
    add_row(apq_pkg::OP_INSERT, 16'hFFFF, 1,  16'h0000, 1'b1, apq_pkg::ST_FULL);
    add_row(apq_pkg::OP_SERVE,  16'h0000, 5,  16'h0000, 1'b0, apq_pkg::ST_SERVED);

    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[n]) begin
      for (int r = 0; r < dir_rows[n].reps; r++) begin
        p = dir_rows[n].price + 16'(r) * dir_rows[n].step;
        send_item(dir_rows[n].kind, p, dir_rows[n].typed, dir_rows[n].st);
      end
    end
    settle();

    set_threshold(8'd1);
    run_random(50);
    settle();

    set_threshold(8'd255);
    run_saturation();
    settle();

    // with a zero threshold, aging applies whenever two entries are held
    set_threshold(8'd0);
    run_random(50);
    settle();

    set_threshold(8'($urandom_range(2, 254)));
    run_random(50);
    settle();

    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("aging_priority_queue regression: pass");
    end else begin
      $display("aging_priority_queue regression: fail");
    end
    $finish;
  end

  // output side stall pattern, with one long hold-off to back the block up
  initial begin
    int n_busy;
    int n_free;
    int r;
    out_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (!held_long && results_seen >= 60) begin
        held_long = 1;
        n_busy = 400;
        n_free = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          n_busy = 0;
          n_free = $urandom_range(10, 40);
        end else if (r < 90) begin
          n_busy = $urandom_range(1, 3);
          n_free = $urandom_range(1, 4);
        end else begin
          n_busy = $urandom_range(10, 60);
          n_free = $urandom_range(1, 4);
        end
      end
      repeat (n_busy) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      repeat (n_free) begin
        @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing pending: status %0d price %h count %0d",
                 $time, status, served_price, served_passed_over);
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.st) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        end
        if (served_price !== want.price) begin
          mismatches++;
          $display("%0t: served_price expected %h actual %h", $time, want.price, served_price);
        end
        if (served_passed_over !== want.cnt) begin
          mismatches++;
          $display("%0t: served_passed_over expected %0d actual %0d",
                   $time, want.cnt, served_passed_over);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results pending",
                 $time, quiet_cycles, pending_outcomes.size());
        $display("aging_priority_queue regression: fail");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
